FILE: hdl/bpc_pkg.sv
`default_nettype none

package bpc_pkg;

    localparam int TIME_W = 32;
    localparam int CFG_W  = 16;
    localparam int IDX_W  = 2;
    localparam int KIND_W = 2;

    // register indexes
    localparam logic [IDX_W-1:0] REG_LONG_PRESS = 2'd0;
    localparam logic [IDX_W-1:0] REG_DOUBLE_GAP = 2'd1;
    localparam logic [IDX_W-1:0] REG_DEBOUNCE   = 2'd2;

    // register reset values
    localparam logic [CFG_W-1:0] LONG_PRESS_RST = 16'd700;
    localparam logic [CFG_W-1:0] DOUBLE_GAP_RST = 16'd280;
    localparam logic [CFG_W-1:0] DEBOUNCE_RST   = 16'd30;

    // press kinds
    localparam logic [KIND_W-1:0] KIND_SHORT  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DOUBLE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_LONG   = 2'd2;

    typedef struct packed {
        logic [CFG_W-1:0] long_press_ms;
        logic [CFG_W-1:0] gap_max_ms;
        logic [CFG_W-1:0] bounce_min_ms;
    } t_cfg;

    typedef struct packed {
        logic              valid;
        logic [KIND_W-1:0] kind;
    } t_result;

endpackage

`default_nettype wire

FILE: hdl/bpc_sample_if.sv
`default_nettype none

interface bpc_sample_if;
    logic                      valid;
    logic                      ready;
    logic                      button_down;
    logic [bpc_pkg::TIME_W-1:0] time_ms;

    modport source (output valid, output button_down, output time_ms, input ready);
    modport sink   (input valid, input button_down, input time_ms, output ready);
endinterface

`default_nettype wire

FILE: hdl/bpc_result_if.sv
`default_nettype none

interface bpc_result_if;
    logic                       valid;
    logic                       ready;
    logic [bpc_pkg::KIND_W-1:0] press_kind;

    modport source (output valid, output press_kind, input ready);
    modport sink   (input valid, input press_kind, output ready);
endinterface

`default_nettype wire

FILE: hdl/button_press_classifier.sv
// Channel   Dir  Word fields                        Handshake
// i_sample  in   button_down[0], time_ms[31:0]      valid/ready
// o_result  out  press_kind[1:0]                    valid/ready
// i_cfg_*   in   index[1:0], data[15:0]             write enable only
//
// One sample word per cycle sustained while results are taken; an accepted word
// is held in the input register, then the state update loads its result register.
// Reset is synchronous, active low; it restores the idle phase and the
// default hold, gap and debounce times.
// A result held in the output register that is not taken stalls the
// input register; the input still accepts while that register is free.
`default_nettype none

module button_press_classifier (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    bpc_sample_if.sink                       i_sample,
    bpc_result_if.source                     o_result,
    input  wire logic                        i_cfg_we,
    input  wire logic [bpc_pkg::IDX_W-1:0]   i_cfg_idx,
    input  wire logic [bpc_pkg::CFG_W-1:0]   i_cfg_data
);

    // configuration registers
    bpc_pkg::t_cfg r_cfg;

    // input register
    logic                       r_in_valid;
    logic                       r_in_down;
    logic [bpc_pkg::TIME_W-1:0] r_in_time;

    // result register
    logic                       r_out_valid;
    logic [bpc_pkg::KIND_W-1:0] r_out_kind;

    logic             w_out_free;
    logic             w_advance;
    logic             w_in_take;
    bpc_pkg::t_result w_res;

    // the result register can take a new word when empty or being drained
    assign w_out_free      = !r_out_valid || o_result.ready;
    assign w_advance       = r_in_valid && w_out_free;
    assign i_sample.ready  = !r_in_valid || w_out_free;
    assign w_in_take       = i_sample.valid && i_sample.ready;

    assign o_result.valid      = r_out_valid;
    assign o_result.press_kind = r_out_kind;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.long_press_ms <= bpc_pkg::LONG_PRESS_RST;
            r_cfg.gap_max_ms    <= bpc_pkg::DOUBLE_GAP_RST;
            r_cfg.bounce_min_ms <= bpc_pkg::DEBOUNCE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                bpc_pkg::REG_LONG_PRESS: r_cfg.long_press_ms <= i_cfg_data;
                bpc_pkg::REG_DOUBLE_GAP: r_cfg.gap_max_ms    <= i_cfg_data;
                bpc_pkg::REG_DEBOUNCE:   r_cfg.bounce_min_ms <= i_cfg_data;
                default: begin
                    // unknown index: drop the write
                end
            endcase
        end
    end

    // hold the sample until the state machine consumes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_take) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_down <= i_sample.button_down;
            r_in_time <= i_sample.time_ms;
        end
    end

    bpc_fsm u_fsm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_advance),
        .i_down  (r_in_down),
        .i_time  (r_in_time),
        .i_cfg   (r_cfg),
        .o_res   (w_res)
    );

    // load a new result or drain the one taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res.valid) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res.valid) begin
            r_out_kind <= w_res.kind;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/bpc_fsm.sv
`default_nettype none

module bpc_fsm (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_en,
    input  wire logic                       i_down,
    input  wire logic [bpc_pkg::TIME_W-1:0] i_time,
    input  wire bpc_pkg::t_cfg              i_cfg,
    output bpc_pkg::t_result                o_res
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_DOWN = 2'd1,
        ST_WAIT = 2'd2,
        ST_LONG = 2'd3
    } t_phase;

    t_phase                       r_phase, n_phase;
    logic [bpc_pkg::TIME_W-1:0]   r_press_start, n_press_start;
    logic [bpc_pkg::TIME_W-1:0]   r_release_time, n_release_time;
    logic                         r_second, n_second;

    logic [bpc_pkg::TIME_W-1:0]   w_held;
    logic [bpc_pkg::TIME_W-1:0]   w_gap;

    // differences wrap modulo 2^32
    assign w_held = i_time - r_press_start;
    assign w_gap  = i_time - r_release_time;

    always_comb begin
        n_phase        = r_phase;
        n_press_start  = r_press_start;
        n_release_time = r_release_time;
        n_second       = r_second;
        o_res.valid    = 1'b0;
        o_res.kind     = bpc_pkg::KIND_SHORT;
        case (r_phase)
            ST_IDLE: begin
                if (i_down) begin
                    n_phase       = ST_DOWN;
                    n_press_start = i_time;
                    n_second      = 1'b0;
                end
            end
            ST_DOWN: begin
                if (i_down) begin
                    if (w_held >= {16'd0, i_cfg.long_press_ms}) begin
                        o_res.valid = 1'b1;
                        o_res.kind  = bpc_pkg::KIND_LONG;
                        n_phase     = ST_LONG;
                    end
                end else if (w_held >= {16'd0, i_cfg.bounce_min_ms}) begin
                    if (r_second) begin
                        o_res.valid = 1'b1;
                        o_res.kind  = bpc_pkg::KIND_DOUBLE;
                        n_phase     = ST_IDLE;
                    end else begin
                        n_release_time = i_time;
                        n_phase        = ST_WAIT;
                    end
                end else begin
                    // too short: drop the press
                    n_phase = ST_IDLE;
                end
            end
            ST_WAIT: begin
                if (i_down) begin
                    n_phase       = ST_DOWN;
                    n_press_start = i_time;
                    n_second      = 1'b1;
                end else if (w_gap >= {16'd0, i_cfg.gap_max_ms}) begin
                    o_res.valid = 1'b1;
                    o_res.kind  = bpc_pkg::KIND_SHORT;
                    n_phase     = ST_IDLE;
                end
            end
            default: begin
                if (!i_down) begin
                    n_phase = ST_IDLE;
                end
            end
        endcase
        o_res.valid = o_res.valid & i_en;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= ST_IDLE;
            r_press_start  <= '0;
            r_release_time <= '0;
            r_second       <= 1'b0;
        end else if (i_en) begin
            r_phase        <= n_phase;
            r_press_start  <= n_press_start;
            r_release_time <= n_release_time;
            r_second       <= n_second;
        end
    end

endmodule

`default_nettype wire

FILE: bench/tb_button_press_classifier.sv
`timescale 1ns / 1ps

module tb_button_press_classifier;

    // index 3 decodes to no register; writes there must leave all settings alone
    localparam logic [bpc_pkg::IDX_W-1:0] REG_SPARE = 2'd3;

    localparam int RESET_CYCLES = 12;
    localparam int SETTLE_CYCLES = 8;     // two-stage pipe plus margin
    localparam int HOLDOFF_CYCLES = 300;
    localparam int CYCLE_LIMIT = 200000;
    localparam int IDLE_PERCENT = 27;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_DOWN = 2'd1,
        PH_WAIT = 2'd2,
        PH_LONG = 2'd3
    } t_press_phase;

    typedef struct packed {
        logic                       down;
        logic [bpc_pkg::TIME_W-1:0] stamp;
    } t_sample_word;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic [bpc_pkg::IDX_W-1:0] i_cfg_idx;
    logic [bpc_pkg::CFG_W-1:0] i_cfg_data;

    bpc_sample_if smp_if ();
    bpc_result_if res_if ();

    button_press_classifier i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_sample   (smp_if),
        .o_result   (res_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Stimulus bookkeeping
    t_sample_word sample_q[$];
    t_sample_word next_word;
    int unsigned queued_total = 0;
    logic [bpc_pkg::TIME_W-1:0] time_cursor;

    // Idling control: quiet turns off random idling on both sides;
    // want_holdoff asks the receiver for one long stall
    bit quiet = 1'b0;
    bit want_holdoff = 1'b0;
    bit holdoff_done = 1'b0;
    int holdoff_left = 0;

    // Predictor: a copy of the classifier's state and its three settings
    t_press_phase press_phase;
    logic [bpc_pkg::TIME_W-1:0] press_start;
    logic [bpc_pkg::TIME_W-1:0] release_time;
    logic second_press;
    logic [bpc_pkg::CFG_W-1:0] hold_ms;
    logic [bpc_pkg::CFG_W-1:0] gap_ms;
    logic [bpc_pkg::CFG_W-1:0] bounce_ms;
    logic [bpc_pkg::KIND_W-1:0] expected_kinds[$];
    logic [bpc_pkg::KIND_W-1:0] oldest_kind;

    int error_count = 0;
    int cycle_count = 0;

    task automatic report_mismatch(input string what);
        $display("mismatch at cycle %0d: %s", cycle_count, what);
        error_count++;
    endtask

    // Advance the gesture state for one accepted sample word and queue
    // the press kind that it reports, if any.
    task automatic classify_sample(input logic down,
                                   input logic [bpc_pkg::TIME_W-1:0] stamp);
        logic [bpc_pkg::TIME_W-1:0] held;
        logic [bpc_pkg::TIME_W-1:0] waited;
        held = stamp - press_start;      // wraps modulo 2^32
        waited = stamp - release_time;
        case (press_phase)
            PH_IDLE: begin
                if (down) begin
                    press_phase = PH_DOWN;
                    press_start = stamp;
                    second_press = 1'b0;
                end
            end
            PH_DOWN: begin
                if (down) begin
                    if (held >= hold_ms) begin
                        expected_kinds.push_back(bpc_pkg::KIND_LONG);
                        press_phase = PH_LONG;
                    end
                end else if (held >= bounce_ms) begin
                    if (second_press) begin
                        expected_kinds.push_back(bpc_pkg::KIND_DOUBLE);
                        press_phase = PH_IDLE;
                    end else begin
                        release_time = stamp;
                        press_phase = PH_WAIT;
                    end
                end else begin
                    // too short to be a real press: drop it
                    press_phase = PH_IDLE;
                end
            end
            PH_WAIT: begin
                if (down) begin
                    press_phase = PH_DOWN;
                    press_start = stamp;
                    second_press = 1'b1;
                end else if (waited >= gap_ms) begin
                    expected_kinds.push_back(bpc_pkg::KIND_SHORT);
                    press_phase = PH_IDLE;
                end
            end
            default: begin
                // long already sent: hold until release
                if (!down) begin
                    press_phase = PH_IDLE;
                end
            end
        endcase
    endtask

    // Sender: offer the next pending word unless idling; keep a word
    // stable until it is taken.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            smp_if.valid <= 1'b0;
        end else if (!smp_if.valid || smp_if.ready) begin
            if (sample_q.size() != 0 && (quiet || $urandom_range(99) >= IDLE_PERCENT)) begin
                next_word = sample_q.pop_front();
                smp_if.valid <= 1'b1;
                smp_if.button_down <= next_word.down;
                smp_if.time_ms <= next_word.stamp;
            end else begin
                smp_if.valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off counted here so the
    // block fills up and pushes back on its input.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else if (holdoff_left > 0) begin
            res_if.ready <= 1'b0;
            holdoff_left <= holdoff_left - 1;
        end else if (want_holdoff && !holdoff_done) begin
            res_if.ready <= 1'b0;
            holdoff_left <= HOLDOFF_CYCLES;
            holdoff_done <= 1'b1;
        end else begin
            res_if.ready <= quiet || ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    // Monitor: check taken results against the oldest expectation, then
    // predict from taken sample words and track register writes.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            press_phase = PH_IDLE;
            press_start = '0;
            release_time = '0;
            second_press = 1'b0;
            hold_ms = bpc_pkg::LONG_PRESS_RST;
            gap_ms = bpc_pkg::DOUBLE_GAP_RST;
            bounce_ms = bpc_pkg::DEBOUNCE_RST;
        end else begin
            if (res_if.valid && res_if.ready) begin
                if (expected_kinds.size() == 0) begin
                    report_mismatch($sformatf("press_kind %0d with nothing pending",
                                              res_if.press_kind));
                end else begin
                    oldest_kind = expected_kinds.pop_front();
                    if (res_if.press_kind !== oldest_kind) begin
                        report_mismatch($sformatf("press_kind %0d, expected %0d",
                                                  res_if.press_kind, oldest_kind));
                    end
                end
            end
            if (smp_if.valid && smp_if.ready) begin
                classify_sample(smp_if.button_down, smp_if.time_ms);
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    bpc_pkg::REG_LONG_PRESS: hold_ms = i_cfg_data;
                    bpc_pkg::REG_DOUBLE_GAP: gap_ms = i_cfg_data;
                    bpc_pkg::REG_DEBOUNCE:   bounce_ms = i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_button_press_classifier: FAIL");
            $finish;
        end
    end

    task automatic push_sample(input logic down, input logic [bpc_pkg::TIME_W-1:0] stamp);
        sample_q.push_back('{down: down, stamp: stamp});
        queued_total++;
    endtask

    // Spread one level over a duration: one to three samples, the last one
    // landing exactly at the end so thresholds are hit on the nose.
    task automatic add_span(input logic down, input int unsigned dur);
        int unsigned parts;
        parts = $urandom_range(1, 3);
        for (int k = 1; k <= parts; k++) begin
            push_sample(down, time_cursor + 32'((longint'(dur) * k) / parts));
        end
        time_cursor = time_cursor + dur;
    endtask

    // Pick a duration on, just around, below or above a threshold.
    function automatic int unsigned near_threshold(input logic [bpc_pkg::CFG_W-1:0] thr);
        int unsigned base;
        base = thr;
        case ($urandom_range(4))
            0: return (base == 0) ? 0 : base - 1;
            1: return base;
            2: return base + 1;
            3: return $urandom_range(base);
            default: return base + $urandom_range(base + 5);
        endcase
    endfunction

    // Mostly well-formed gestures with random timing; the rest is noise,
    // wrap-around jumps and timestamps that step backwards.
    task automatic queue_gestures(input int unsigned count);
        int unsigned target;
        int unsigned choice;
        target = queued_total + count;
        while (queued_total < target) begin
            choice = $urandom_range(99);
            if (choice < 25) begin
                add_span(1'b1, near_threshold(bounce_ms));
                add_span(1'b0, near_threshold(gap_ms));
            end else if (choice < 45) begin
                add_span(1'b1, near_threshold(bounce_ms));
                add_span(1'b0, $urandom_range(gap_ms));
                add_span(1'b1, near_threshold(bounce_ms));
                add_span(1'b0, near_threshold(gap_ms));
            end else if (choice < 65) begin
                add_span(1'b1, near_threshold(hold_ms));
                add_span(1'b1, $urandom_range(20));
                add_span(1'b0, near_threshold(bounce_ms));
            end else if (choice < 75) begin
                add_span(1'b1, $urandom_range(bounce_ms));
                add_span(1'b0, near_threshold(gap_ms));
            end else if (choice < 85) begin
                time_cursor = $urandom;
                push_sample(1'($urandom_range(1)), time_cursor);
            end else if (choice < 92) begin
                time_cursor = 32'hFFFF_FFFF - $urandom_range(200);
            end else begin
                push_sample(1'($urandom_range(1)), time_cursor - $urandom_range(1, 100));
            end
        end
    endtask

    task automatic write_reg(input logic [bpc_pkg::IDX_W-1:0] idx,
                             input logic [bpc_pkg::CFG_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_timing(input logic [bpc_pkg::CFG_W-1:0] hold,
                              input logic [bpc_pkg::CFG_W-1:0] gap,
                              input logic [bpc_pkg::CFG_W-1:0] bounce);
        write_reg(bpc_pkg::REG_LONG_PRESS, hold);
        write_reg(bpc_pkg::REG_DOUBLE_GAP, gap);
        write_reg(bpc_pkg::REG_DEBOUNCE, bounce);
    endtask

    // Wait until every word is taken and every result is in, then let the
    // pipe run dry so a word that caused nothing is fully through.
    task automatic drain;
        while (sample_q.size() != 0 || smp_if.valid || expected_kinds.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        smp_if.valid = 1'b0;
        smp_if.button_down = 1'b0;
        smp_if.time_ms = '0;
        res_if.ready = 1'b0;
        time_cursor = $urandom;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed, at reset timing (hold 700, gap 280, debounce 30)
        push_sample(1'b0, 32'd0);              // release while idle: nothing
        // short press: the gap is one ms short of its limit, then expires on it
        push_sample(1'b1, 32'd100);
        push_sample(1'b1, 32'd150);
        push_sample(1'b0, 32'd200);
        push_sample(1'b0, 32'd479);
        push_sample(1'b0, 32'd480);
        // double press, second press begins inside the wait
        push_sample(1'b1, 32'd1000);
        push_sample(1'b0, 32'd1040);
        push_sample(1'b1, 32'd1100);
        push_sample(1'b0, 32'd1200);
        // long press: one short of the hold, then on it, then held on
        push_sample(1'b1, 32'd2000);
        push_sample(1'b1, 32'd2699);
        push_sample(1'b1, 32'd2700);
        push_sample(1'b1, 32'd3000);
        push_sample(1'b0, 32'd3100);
        // bounce one ms short of debounce: dropped
        push_sample(1'b1, 32'd4000);
        push_sample(1'b0, 32'd4029);
        // press across the timestamp wrap, then the gap runs out
        push_sample(1'b1, 32'hFFFF_FFFF);
        push_sample(1'b0, 32'h0000_002F);
        push_sample(1'b0, 32'h0000_0200);
        // timestamp stepping backwards looks like a very long hold
        push_sample(1'b1, 32'd5000);
        push_sample(1'b1, 32'd4990);
        push_sample(1'b0, 32'd0);
        drain();

        // Fast timing; the spare index must change nothing. Stall the
        // receiver for a long stretch while the sender keeps offering.
        set_timing(16'd120, 16'd60, 16'd10);
        write_reg(REG_SPARE, 16'hFFFF);
        queue_gestures(250);
        want_holdoff <= 1'b1;
        drain();

        // All thresholds zero: every comparison is met
        set_timing(16'd0, 16'd0, 16'd0);
        queue_gestures(120);
        drain();

        // All thresholds at their maximum
        set_timing(16'hFFFF, 16'hFFFF, 16'hFFFF);
        queue_gestures(150);
        drain();

        // Tiny thresholds, no idling on either side
        set_timing(16'd3, 16'd2, 16'd1);
        quiet <= 1'b1;
        queue_gestures(200);
        drain();
        quiet <= 1'b0;

        // Mixed extremes, then back to the reset timing
        set_timing(16'hFFFF, 16'd0, 16'hFFFF);
        queue_gestures(90);
        drain();
        set_timing(bpc_pkg::LONG_PRESS_RST, bpc_pkg::DOUBLE_GAP_RST, bpc_pkg::DEBOUNCE_RST);
        queue_gestures(90);
        drain();

        if (error_count == 0) begin
            $display("tb_button_press_classifier: PASS");
        end else begin
            $display("tb_button_press_classifier: FAIL");
        end
        $finish;
    end

endmodule

FILE: button_press_classifier.f
hdl/bpc_pkg.sv
hdl/bpc_sample_if.sv
hdl/bpc_result_if.sv
hdl/bpc_fsm.sv
hdl/button_press_classifier.sv
bench/tb_button_press_classifier.sv
